### rtl/i2cm_pkg.sv
// i2cm_pkg: shared types, codes and widths of the I2C master bit engine.
// Used by i2cm_core and i2c_master_bit_engine_top; no dependencies.
package i2cm_pkg;

    localparam int unsigned MODE_W     = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned S_TDATA_W  = 16;  // 12 field bits, padded to bytes
    localparam int unsigned M_TDATA_W  = 16;  // 15 field bits, padded to bytes
    localparam int unsigned ACK_TIMEOUT_W     = 8;
    localparam logic [ACK_TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd21;

    // Command codes carried in mode; the unused codes act as no command.
    localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SEND    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RX_ACK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RX_NACK = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_ACK  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BUS_BSY = 2'd2;

    localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_CHK = 4'd1,
        PH_STOP_HIGH = 4'd2,
        PH_STOP_END  = 4'd3,
        PH_TX_LOW    = 4'd4,
        PH_TX_HIGH   = 4'd5,
        PH_WACK_LOW  = 4'd6,
        PH_WACK_HIGH = 4'd7,
        PH_RX_HIGH   = 4'd8,
        PH_RX_LOW    = 4'd9,
        PH_AK_LOW    = 4'd10,
        PH_AK_HIGH   = 4'd11
    } t_phase;

    // One input tick.
    typedef struct packed {
        logic               sda_level;
        logic [BYTE_W-1:0]  tx_byte;
        logic [MODE_W-1:0]  mode;
    } t_tick;

    // One result item, packed so that scl_level lands in bit 0.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   rx_byte;
        logic                done_res;
        logic                busy_res;
        logic                sda_enable;
        logic                sda_drive;
        logic                scl_level;
    } t_result;

endpackage

### rtl/i2c_master_bit_engine_top.sv
// i2c_master_bit_engine_top: stream wrapper of the I2C master bit engine.
// Depends on i2cm_pkg and i2cm_core.
//
//  channel   dir  handshake                    payload
//  --------  ---  ---------------------------  ------------------------------------
//  s_axis    in   i_s_axis_tvalid/o_..._tready tick: mode, tx_byte, sda_level
//  m_axis    out  o_m_axis_tvalid/i_..._tready result: drive, busy/done, rx, status
//  cfg       in   i_cfg_we                     ack_timeout, 8 bits
//
// One tick per clock sustained while i_m_axis_tready stays high. A tick is
// captured in the input register; the engine state and the result register
// then update together when the tick steps. The result register holding
// back (i_m_axis_tready low) stalls the input register, which then stalls
// the input side; nothing is dropped. Reset (synchronous, active low) empties
// both registers and returns the engine to idle with both lines released and
// ack_timeout = 21.
module i2c_master_bit_engine_top
    import i2cm_pkg::*;
#(
    parameter logic [ACK_TIMEOUT_W-1:0] P_ACK_TIMEOUT_RST = ACK_TIMEOUT_RST
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration: ack_timeout
    input  logic                     i_cfg_we,
    input  logic [ACK_TIMEOUT_W-1:0] i_cfg_wdata,
    // input ticks
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // [2:0] mode, [10:3] tx_byte, [11] sda_level, [15:12] zero
    input  logic [S_TDATA_W-1:0]     i_s_axis_tdata,
    // results
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // [0] scl_level, [1] sda_drive, [2] sda_enable, [3] busy_res,
    // [4] done_res, [12:5] rx_byte, [14:13] status, [15] zero
    output logic [M_TDATA_W-1:0]     o_m_axis_tdata
);

    localparam int unsigned TICK_W = $bits(t_tick);
    localparam int unsigned RES_W  = $bits(t_result);

    logic    r_in_valid;
    t_tick   r_in_tick;
    logic    r_out_valid;
    t_result r_out_res;
    t_result w_res;
    logic    w_step;
    logic    w_out_free;

    // The result register frees up when empty or when its transfer completes.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_tick <= t_tick'(i_s_axis_tdata[TICK_W-1:0]);
        end
    end

    i2cm_core #(
        .P_ACK_TIMEOUT_RST (P_ACK_TIMEOUT_RST)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_tick      (r_in_tick),
        .o_result    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, r_out_res};

endmodule

### rtl/i2cm_core.sv
// i2cm_core: engine state registers and the per-tick next-state logic.
// Depends on i2cm_pkg. Advances one tick whenever i_step is high.
module i2cm_core
    import i2cm_pkg::*;
#(
    parameter logic [ACK_TIMEOUT_W-1:0] P_ACK_TIMEOUT_RST = ACK_TIMEOUT_RST
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [ACK_TIMEOUT_W-1:0] i_cfg_wdata,
    input  logic                     i_step,
    input  t_tick                    i_tick,
    output t_result                  o_result
);

    logic [ACK_TIMEOUT_W-1:0] r_ack_timeout;
    t_phase                   r_phase,  n_phase;
    logic [MODE_W-1:0]        r_cmd,    n_cmd;
    logic [CNT_W-1:0]         r_bits,   n_bits;
    logic [BYTE_W-1:0]        r_shift,  n_shift;
    logic [BYTE_W-1:0]        r_retry,  n_retry;
    logic                     r_scl,    n_scl;
    logic                     r_sda,    n_sda;
    logic                     r_sda_en, n_sda_en;
    logic [BYTE_W-1:0]        r_rx,     n_rx;
    logic [STATUS_W-1:0]      r_status, n_status;
    logic                     n_done;
    logic [CNT_W-1:0]         w_bits_dec;
    logic [BYTE_W-1:0]        w_shift_l;

    assign w_bits_dec = r_bits - 1'b1;
    assign w_shift_l  = {r_shift[BYTE_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= P_ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_ack_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cmd    <= MODE_NONE;
            r_bits   <= '0;
            r_shift  <= '0;
            r_retry  <= '0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_sda_en <= 1'b1;
            r_rx     <= '0;
            r_status <= STATUS_OK;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_bits   <= n_bits;
            r_shift  <= n_shift;
            r_retry  <= n_retry;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            r_sda_en <= n_sda_en;
            r_rx     <= n_rx;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_bits   = r_bits;
        n_shift  = r_shift;
        n_retry  = r_retry;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_sda_en = r_sda_en;
        n_rx     = r_rx;
        n_status = r_status;
        n_done   = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                unique case (i_tick.mode)
                    MODE_START: begin
                        n_cmd    = i_tick.mode;
                        n_scl    = 1'b1;
                        n_sda    = 1'b1;
                        n_sda_en = 1'b1;
                        n_phase  = PH_START_CHK;
                    end
                    MODE_STOP: begin
                        n_cmd    = i_tick.mode;
                        n_scl    = 1'b0;
                        n_sda    = 1'b0;
                        n_sda_en = 1'b1;
                        n_phase  = PH_STOP_HIGH;
                    end
                    MODE_SEND: begin
                        n_cmd    = i_tick.mode;
                        n_shift  = i_tick.tx_byte;
                        n_bits   = BITS_PER_BYTE;
                        n_scl    = 1'b0;
                        n_sda    = i_tick.tx_byte[BYTE_W-1];
                        n_sda_en = 1'b1;
                        n_phase  = PH_TX_LOW;
                    end
                    MODE_RX_ACK, MODE_RX_NACK: begin
                        n_cmd    = i_tick.mode;
                        n_shift  = '0;
                        n_bits   = BITS_PER_BYTE;
                        n_scl    = 1'b1;
                        n_sda    = 1'b1;
                        n_sda_en = 1'b0;
                        n_phase  = PH_RX_HIGH;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            PH_START_CHK: begin
                // low SDA while released means another master holds the bus
                if (!i_tick.sda_level) begin
                    n_status = STATUS_BUS_BSY;
                end else begin
                    n_sda    = 1'b0;
                    n_status = STATUS_OK;
                end
                n_phase = PH_IDLE;
                n_done  = 1'b1;
            end
            PH_STOP_HIGH: begin
                n_scl   = 1'b1;
                n_sda   = 1'b0;
                n_phase = PH_STOP_END;
            end
            PH_STOP_END: begin
                n_sda    = 1'b1;
                n_status = STATUS_OK;
                n_phase  = PH_IDLE;
                n_done   = 1'b1;
            end
            PH_TX_LOW: begin
                n_scl   = 1'b1;
                n_phase = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
                n_shift = w_shift_l;
                n_bits  = w_bits_dec;
                n_scl   = 1'b0;
                if (w_bits_dec != '0) begin
                    n_sda   = w_shift_l[BYTE_W-1];
                    n_phase = PH_TX_LOW;
                end else begin
                    n_sda    = 1'b1;
                    n_sda_en = 1'b0;
                    n_retry  = '0;
                    n_phase  = PH_WACK_LOW;
                end
            end
            PH_WACK_LOW: begin
                n_scl   = 1'b1;
                n_phase = PH_WACK_HIGH;
            end
            PH_WACK_HIGH: begin
                if (!i_tick.sda_level) begin
                    n_scl    = 1'b0;
                    n_status = STATUS_OK;
                    n_phase  = PH_IDLE;
                    n_done   = 1'b1;
                end else if (r_retry >= r_ack_timeout) begin
                    n_scl    = 1'b0;
                    n_status = STATUS_NO_ACK;
                    n_phase  = PH_IDLE;
                    n_done   = 1'b1;
                end else begin
                    n_retry = r_retry + 1'b1;
                end
            end
            PH_RX_HIGH: begin
                n_shift = {r_shift[BYTE_W-2:0], i_tick.sda_level};
                n_bits  = w_bits_dec;
                n_scl   = 1'b0;
                n_phase = PH_RX_LOW;
            end
            PH_RX_LOW: begin
                if (r_bits != '0) begin
                    n_scl   = 1'b1;
                    n_phase = PH_RX_HIGH;
                end else begin
                    n_rx     = r_shift;
                    n_scl    = 1'b0;
                    n_sda_en = 1'b1;
                    n_sda    = (r_cmd == MODE_RX_NACK);
                    n_phase  = PH_AK_LOW;
                end
            end
            PH_AK_LOW: begin
                n_scl   = 1'b1;
                n_phase = PH_AK_HIGH;
            end
            PH_AK_HIGH: begin
                n_scl    = 1'b0;
                n_status = STATUS_OK;
                n_phase  = PH_IDLE;
                n_done   = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.scl_level  = n_scl;
        o_result.sda_drive  = n_sda;
        o_result.sda_enable = n_sda_en;
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.done_res   = n_done;
        o_result.rx_byte    = n_rx;
        o_result.status     = n_status;
    end

endmodule
